@@ hw/rtl/tmr_pkg.sv @@
// Shared types and constants of the tile map ray march wall slice unit.
// Holds the sine series used to fill the lookup ROM and the controller/datapath command structs.
// No dependencies.
package tmr_pkg;

    localparam int MapW = 16;
    localparam int MapH = 16;
    localparam int AngleBits = 12;
    localparam int QuarterBits = AngleBits - 2;
    localparam int QuarterSteps = 1 << QuarterBits;

    // Configuration register indices.
    localparam logic [2:0] REG_MAP0 = 3'd0;
    localparam logic [2:0] REG_MAP1 = 3'd1;
    localparam logic [2:0] REG_MAP2 = 3'd2;
    localparam logic [2:0] REG_MAP3 = 3'd3;
    localparam logic [2:0] REG_MAXD = 3'd4;
    localparam logic [2:0] REG_PPD  = 3'd5;
    localparam logic [2:0] REG_SCRH = 3'd6;

    // Trig lookup selectors: which angle is read and which register takes the value.
    localparam logic [1:0] TRIG_RAY_COS  = 2'd0;
    localparam logic [1:0] TRIG_RAY_SIN  = 2'd1;
    localparam logic [1:0] TRIG_VIEW_COS = 2'd2;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [11:0] ray_angle;
        logic [11:0] view_offset;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [14:0] distance;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic [4:0]  tile_x;
        logic [4:0]  tile_y;
        logic [11:0] wall_top;
        logic [11:0] wall_bottom;
    } t_out;

    typedef struct packed { logic [2:0] index; logic [63:0] data; } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch request
        logic trig_rd;   // read the sine ROM
        logic [1:0] trig_sel; // angle to look up
        logic trig_wr;   // store the value read in the previous cycle
        logic [1:0] trig_dst; // register that takes it
        logic step;      // advance the ray by one step
        logic mul;       // form corrected distance
        logic div_start; // seed the divider
        logic div_step;  // one restoring division bit
        logic finish;    // form the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stop;     // current position ends the march
        logic d_pos;    // ray hit a wall and corrected distance is positive
    } t_sts;

    // Multiplies a series term by x twice in Q30, truncating after each product.
    function automatic longint series_power(input longint t, input longint x);
        longint p;
        p = t * x / 64'sd1073741824;
        p = p * x / 64'sd1073741824;
        return p;
    endfunction

    // Quarter-wave sine in Q1.14, used only to fill the lookup ROM.
    function automatic logic [14:0] quarter_sine(input int k);
        longint x, t, s;
        x = (longint'(k) * 64'sd1686629713) >>> QuarterBits;
        t = x;
        s = x;
        // Each term is the previous one times -x^2 over (2n)(2n+1), truncated.
        t = -(series_power(t, x) / 64'sd6);
        s += t;
        t = -(series_power(t, x) / 64'sd20);
        s += t;
        t = -(series_power(t, x) / 64'sd42);
        s += t;
        t = -(series_power(t, x) / 64'sd72);
        s += t;
        t = -(series_power(t, x) / 64'sd110);
        s += t;
        t = -(series_power(t, x) / 64'sd156);
        s += t;
        if (s < 0) s = 0;
        s = (s + 32768) >>> 16;
        if (s > 16384) s = 16384;
        return s[14:0];
    endfunction

endpackage

@@ hw/rtl/tmr_if.sv @@
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on tmr_pkg for the payload types.
interface tmr_in_if;
    logic valid;
    logic ready;
    tmr_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmr_out_if;
    logic valid;
    logic ready;
    tmr_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmr_cfg_if;
    logic valid;
    logic ready;
    tmr_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tile_map_ray_march_wall_slice_unit.sv @@
// Tile map ray march wall slice unit: one result per ray.
// Each ray runs through sine ROM lookups, the march (one step per cycle plus the stopping test),
// a distance multiply and, for a hit with a positive corrected distance, a 36-bit bit-serial
// divider for the slice height.
// One ray at a time; the next request is taken the cycle after the result leaves.
// Synchronous active-low reset restores the default configuration and idles the unit.
module tile_map_ray_march_wall_slice_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tmr_in_if.sink    in_ch,
    tmr_out_if.source out_ch,
    tmr_cfg_if.sink   cfg_ch
);
    import tmr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign cfg_ch.ready = 1'b1;

    tmr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    tmr_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_req(in_ch.data),
        .i_cfg_we(cfg_ch.valid), .i_cfg(cfg_ch.data),
        .o_sts(sts), .o_res(out_ch.data)
    );
endmodule

@@ hw/rtl/tmr_ctrl.sv @@
// Controller state machine of the ray march unit.
// Depends on tmr_pkg for the command and status structs.
module tmr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tmr_pkg::t_sts  i_sts,
    output tmr_pkg::t_cmd  o_cmd
);
    import tmr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TRIG_C, S_TRIG_S, S_TRIG_V, S_TRIG_W,
        S_MARCH, S_MUL, S_DIVI, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TRIG_C;
                end
            end
            // Three ROM reads back to back, each stored in the following cycle.
            S_TRIG_C: begin
                o_cmd.trig_rd = 1'b1;
                o_cmd.trig_sel = TRIG_RAY_COS;
                n_state = S_TRIG_S;
            end
            S_TRIG_S: begin
                o_cmd.trig_rd = 1'b1;
                o_cmd.trig_sel = TRIG_RAY_SIN;
                o_cmd.trig_wr = 1'b1;
                o_cmd.trig_dst = TRIG_RAY_COS;
                n_state = S_TRIG_V;
            end
            S_TRIG_V: begin
                o_cmd.trig_rd = 1'b1;
                o_cmd.trig_sel = TRIG_VIEW_COS;
                o_cmd.trig_wr = 1'b1;
                o_cmd.trig_dst = TRIG_RAY_SIN;
                n_state = S_TRIG_W;
            end
            S_TRIG_W: begin
                o_cmd.trig_wr = 1'b1;
                o_cmd.trig_dst = TRIG_VIEW_COS;
                n_state = S_MARCH;
            end
            S_MARCH: begin
                if (i_sts.stop) n_state = S_MUL;
                else o_cmd.step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_start = 1'b1;
                n_cnt = 6'd0;
                n_state = i_sts.d_pos ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd35) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ hw/rtl/tmr_dp.sv @@
// Datapath of the ray march unit: sine ROM, position accumulators, map lookup,
// distance multiply, serial divider and slice clamp. Depends on tmr_pkg.
module tmr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmr_pkg::t_cmd  i_cmd,
    input  tmr_pkg::t_in   i_req,
    input  logic           i_cfg_we,
    input  tmr_pkg::t_cfg  i_cfg,
    output tmr_pkg::t_sts  o_sts,
    output tmr_pkg::t_out  o_res
);
    import tmr_pkg::*;

    logic [63:0] r_map [4];
    logic [14:0] r_maxd;
    logic [11:0] r_ppd;
    logic [11:0] r_scrh;

    logic signed [30:0] r_px, r_py;   // position in 2^-24 tile, range fits 31 bits
    logic signed [15:0] r_c, r_s, r_cv;
    logic [14:0] r_n;
    logic signed [31:0] r_d;
    logic [35:0] r_quo;
    logic [35:0] r_rem;
    logic [35:0] r_num;
    logic r_hit;
    t_out r_res;
    t_in r_req;
    logic [14:0] r_rom;
    logic r_rom_neg;
    logic [14:0] sine_rom [0:QuarterSteps];

    // Quarter-wave sine ROM, filled from the series at elaboration.
    initial begin
        for (int k = 0; k <= QuarterSteps; k++) sine_rom[k] = quarter_sine(k);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_map[i] <= '0;
            r_maxd <= 15'd25600;
            r_ppd <= 12'd831;
            r_scrh <= 12'd600;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: r_map[i_cfg.index[1:0]] <= i_cfg.data;
                REG_MAXD: r_maxd <= i_cfg.data[14:0];
                REG_PPD:  r_ppd <= i_cfg.data[11:0];
                REG_SCRH: r_scrh <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // Lookup address: a cosine is the sine a quarter turn on, mirrored in odd quadrants.
    logic [AngleBits-1:0] trig_ang;
    logic [QuarterBits-1:0] trig_r;
    logic [QuarterBits:0] rom_idx;
    logic signed [15:0] rom_val;
    always_comb begin
        case (i_cmd.trig_sel)
            TRIG_RAY_COS:  trig_ang = r_req.ray_angle + (AngleBits)'(QuarterSteps);
            TRIG_RAY_SIN:  trig_ang = r_req.ray_angle;
            TRIG_VIEW_COS: trig_ang = r_req.view_offset + (AngleBits)'(QuarterSteps);
            default:       trig_ang = r_req.ray_angle;
        endcase
    end
    assign trig_r = trig_ang[QuarterBits-1:0];
    assign rom_idx = trig_ang[QuarterBits] ?
                     (QuarterBits+1)'(QuarterSteps) - {1'b0, trig_r} : {1'b0, trig_r};
    assign rom_val = r_rom_neg ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});

    // Stop test on the current position.
    logic oob, wall;
    logic [3:0] tx, ty;
    logic [63:0] row;
    assign oob = r_px[30] | r_py[30] | (|r_px[29:28]) | (|r_py[29:28]);
    assign tx = r_px[27:24];
    assign ty = r_py[27:24];
    assign row = r_map[ty[3:2]];
    assign wall = row[{ty[1:0], tx}];
    assign o_sts.stop = oob | wall | (r_n >= r_maxd);
    assign o_sts.d_pos = r_hit & (r_d > 0);

    logic signed [30:0] sx, sy;
    assign sx = $signed({3'b0, i_req.start_x, 12'b0});
    assign sy = $signed({3'b0, i_req.start_y, 12'b0});

    logic [11:0] h2;
    logic [35:0] sl, up, dn;
    logic [12:0] bot;
    logic [36:0] trial;
    assign h2 = r_scrh >> 1;
    assign sl = r_quo;
    assign up = (sl + 36'd1) >> 1;
    assign dn = sl >> 1;
    assign bot = {1'b0, h2} + ((dn > 36'd4095) ? 13'd4095 : {1'b0, dn[11:0]});
    assign trial = {r_rem, r_num[35]} - {5'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_px <= sx;
            r_py <= sy;
            r_n <= '0;
        end
        // ROM read with registered data, stored into its register in the following cycle.
        if (i_cmd.trig_rd) begin
            r_rom <= sine_rom[rom_idx];
            r_rom_neg <= trig_ang[AngleBits-1];
        end
        if (i_cmd.trig_wr) begin
            case (i_cmd.trig_dst)
                TRIG_RAY_COS:  r_c <= rom_val;
                TRIG_RAY_SIN:  r_s <= rom_val;
                TRIG_VIEW_COS: r_cv <= rom_val;
                default: ;
            endcase
        end
        if (i_cmd.step) begin
            r_px <= r_px + 31'(r_c);
            r_py <= r_py + 31'(r_s);
            r_n <= r_n + 15'd1;
        end
        if (i_cmd.mul) begin
            r_hit <= ~oob & wall;
            r_d <= 32'($signed({1'b0, r_n})) * 32'(r_cv);
        end
        if (i_cmd.div_start) begin
            r_num <= {r_ppd, 24'b0};
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            if (!trial[36]) begin
                r_rem <= trial[35:0];
                r_quo <= {r_quo[34:0], 1'b1};
            end else begin
                r_rem <= {r_rem[34:0], r_num[35]};
                r_quo <= {r_quo[34:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            if (r_hit) begin
                r_res.hit <= 1'b1;
                r_res.distance <= r_n;
                r_res.hit_x <= r_px[27:12];
                r_res.hit_y <= r_py[27:12];
                r_res.tile_x <= {1'b0, tx};
                r_res.tile_y <= {1'b0, ty};
                if (r_d <= 0) begin
                    r_res.wall_top <= '0;
                    r_res.wall_bottom <= r_scrh;
                end else begin
                    r_res.wall_top <= (up >= {24'b0, h2}) ? 12'd0 : h2 - up[11:0];
                    r_res.wall_bottom <= (bot > {1'b0, r_scrh}) ? r_scrh : bot[11:0];
                end
            end else begin
                r_res.hit <= 1'b0;
                r_res.distance <= '0;
                r_res.hit_x <= '0;
                r_res.hit_y <= '0;
                r_res.tile_x <= 5'h1f;
                r_res.tile_y <= 5'h1f;
                r_res.wall_top <= h2;
                r_res.wall_bottom <= h2;
            end
        end
    end

    assign o_res = r_res;
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the tile map ray march wall slice unit. Drives rays and
// register writes over valid/ready channels and checks every result against a behavioural
// predictor of the march or a fixed value. Depends on tmr_pkg and the tmr_*_if interfaces.
`timescale 1ns / 1ps

module tb;
    import tmr_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;   // index past the register list, ignored
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD = 500;

    typedef struct {
        t_in  ray;
        bit   typed;
        t_out want;
        bit   border_first;   // load the border map before this request
    } t_ray_row;

    logic i_clk;
    logic i_rst_n;

    tmr_in_if  in_ch ();
    tmr_out_if out_ch ();
    tmr_cfg_if cfg_ch ();

    tile_map_ray_march_wall_slice_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    // Predictor copy of the configuration.
    logic [63:0] map_reg [4];
    logic [14:0] march_limit;
    logic [11:0] plane_dist;
    logic [11:0] scr_rows;

    longint sine_quarter [0:1024];
    t_out   slice_q [$];
    int     n_errors;
    int     n_results;
    int     idle_cycles;
    bit     typed_pending;
    t_out   typed_slice;

    // Clock.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Quarter-wave sine table in Q1.14 from a truncating Taylor series in Q30.
    function automatic longint quarter_wave(input longint k);
        longint x, t, acc;
        x = k * 64'sd1686629713 / 1024;
        t = x;
        acc = x;
        for (int n = 1; n <= 6; n++) begin
            t = t * x / 64'sd1073741824;
            t = t * x / 64'sd1073741824;
            t = t / ((2 * n) * (2 * n + 1));
            t = -t;
            acc += t;
        end
        if (acc < 0) acc = 0;
        acc = (acc + 32768) >>> 16;
        if (acc > 16384) acc = 16384;
        return acc;
    endfunction

    function automatic longint sine_of(input logic [11:0] a);
        logic [9:0] r;
        r = a[9:0];
        case (a[11:10])
            2'd0: return sine_quarter[r];
            2'd1: return sine_quarter[1024 - r];
            2'd2: return -sine_quarter[r];
            default: return -sine_quarter[1024 - r];
        endcase
    endfunction

    function automatic longint cosine_of(input logic [11:0] a);
        return sine_of(a + 12'd1024);
    endfunction

    function automatic bit wall_at(input longint tx, input longint ty);
        logic [63:0] rows;
        rows = map_reg[(ty >> 2) & 3];
        return rows[((ty & 3) * 16 + (tx & 15)) & 63];
    endfunction

    // Marches one ray through the map and forms the wall slice.
    function automatic t_out march_ray(input t_in r);
        longint sx, sy, c, s, n, px, py, tx, ty, d;
        longint unsigned sl, up, dn, top, bot, h2;
        bit oob, wall;
        t_out o;
        sx = longint'(r.start_x) * 4096;
        sy = longint'(r.start_y) * 4096;
        c = cosine_of(r.ray_angle);
        s = sine_of(r.ray_angle);
        n = 0; px = sx; py = sy; tx = 0; ty = 0;
        h2 = scr_rows >> 1;
        while (1) begin
            oob = px < 0 || py < 0;
            if (!oob) begin
                tx = px >>> 24;
                ty = py >>> 24;
                oob = tx >= 16 || ty >= 16;
            end
            wall = !oob && wall_at(tx, ty);
            if (oob || wall || n >= longint'(march_limit)) break;
            n++;
            px = sx + n * c;
            py = sy + n * s;
        end
        if (wall) begin
            d = n * cosine_of(r.view_offset);
            if (d <= 0) begin
                top = 0;
                bot = scr_rows;
            end else begin
                sl = (longint'(plane_dist) << 24) / d;
                up = (sl + 1) >> 1;
                dn = sl >> 1;
                top = (up >= h2) ? 0 : h2 - up;
                bot = h2 + dn;
                if (bot > scr_rows) bot = scr_rows;
            end
            o.hit = 1'b1;
            o.distance = n[14:0];
            o.hit_x = 16'(px >>> 12);
            o.hit_y = 16'(py >>> 12);
            o.tile_x = tx[4:0];
            o.tile_y = ty[4:0];
            o.wall_top = top[11:0];
            o.wall_bottom = bot[11:0];
        end else begin
            o = '0;
            o.tile_x = 5'h1F;
            o.tile_y = 5'h1F;
            o.wall_top = h2[11:0];
            o.wall_bottom = h2[11:0];
        end
        return o;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d, expected %0d (result %0d, t=%0t)",
                 what, got, want, n_results, $realtime);
        n_errors++;
    endtask

    // Request monitor: queues the expected result of each accepted ray and tracks register writes.
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.data.index)
                REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3:
                    map_reg[cfg_ch.data.index[1:0]] = cfg_ch.data.data;
                REG_MAXD: march_limit = cfg_ch.data.data[14:0];
                REG_PPD:  plane_dist = cfg_ch.data.data[11:0];
                REG_SCRH: scr_rows = cfg_ch.data.data[11:0];
                default: ;
            endcase
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            slice_q.push_back(typed_pending ? typed_slice : march_ray(in_ch.data));
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (slice_q.size() == 0) begin
                $display("unexpected result at t=%0t", $realtime);
                n_errors++;
            end else begin
                want = slice_q.pop_front();
                if (got.hit != want.hit) report("hit", got.hit, want.hit);
                if (got.distance != want.distance)
                    report("distance", got.distance, want.distance);
                if (got.hit_x != want.hit_x) report("hit_x", got.hit_x, want.hit_x);
                if (got.hit_y != want.hit_y) report("hit_y", got.hit_y, want.hit_y);
                if (got.tile_x != want.tile_x) report("tile_x", got.tile_x, want.tile_x);
                if (got.tile_y != want.tile_y) report("tile_y", got.tile_y, want.tile_y);
                if (got.wall_top != want.wall_top)
                    report("wall_top", got.wall_top, want.wall_top);
                if (got.wall_bottom != want.wall_bottom)
                    report("wall_bottom", got.wall_bottom, want.wall_bottom);
            end
            n_results++;
        end
    end

    // Watchdog on cycles in which no request or result moves.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall patterns that change every so often, and one long hold-off.
    initial begin
        int mode, left, hold;
        bit held;
        out_ch.ready = 1'b0;
        mode = 0; left = 0; hold = 0; held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && n_results >= 20) begin
                held = 1;
                hold = LONG_HOLD;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            if (hold > 0) begin
                hold--;
                out_ch.ready = 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = ($urandom_range(0, 9) < 7);
                    default: out_ch.ready = ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Sender helpers: all driving happens at the falling edge.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.data.index = idx;
        cfg_ch.data.data = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Leaves valid high; the caller drops it later, through pause_rays, wait_drained or directly.
    task automatic send_ray(input t_in r);
        in_ch.valid = 1'b1;
        in_ch.data = r;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause_rays(input int cycles);
        in_ch.valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (slice_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_map(input logic [63:0] m0, m1, m2, m3);
        write_reg(REG_MAP0, m0);
        write_reg(REG_MAP1, m1);
        write_reg(REG_MAP2, m2);
        write_reg(REG_MAP3, m3);
    endtask

    function automatic t_in random_ray();
        t_in r;
        r.start_x = 16'($urandom);
        r.start_y = 16'($urandom);
        r.ray_angle = 12'($urandom);
        // Mostly columns near the view centre, sometimes any angle.
        if ($urandom_range(0, 3) == 0) r.view_offset = 12'($urandom);
        else r.view_offset = 12'($urandom_range(0, 600) - 300);
        return r;
    endfunction

    // Random rays in bursts, with one pause until everything has come back if drain_pause is set.
    task automatic random_rays(input int count, input bit drain_pause);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && count > 0) begin
                send_ray(random_ray());
                burst--;
                count--;
            end
            if (drain_pause && count < 15) begin
                drain_pause = 0;
                wait_drained();
            end else if ($urandom_range(0, 2) != 0) begin
                pause_rays($urandom_range(1, 6));
            end
        end
        in_ch.valid = 1'b0;
    endtask

    // Main sequence.
    initial begin
        t_ray_row rows [$];
        t_out none300, wall_lo, wall_hi;
        logic [63:0] m2;
        n_errors = 0; n_results = 0; idle_cycles = 0;
        typed_pending = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        for (int k = 0; k <= 1024; k++) sine_quarter[k] = quarter_wave(k);
        map_reg[0] = '0; map_reg[1] = '0; map_reg[2] = '0; map_reg[3] = '0;
        march_limit = 15'd25600;
        plane_dist = 12'd831;
        scr_rows = 12'd600;

        // Values read straight off the defaults and the border map.
        none300 = '{1'b0, 15'd0, 16'd0, 16'd0, 5'h1F, 5'h1F, 12'd300, 12'd300};
        wall_lo = '{1'b1, 15'd0, 16'h0800, 16'h0800, 5'd0, 5'd0, 12'd0, 12'd600};
        wall_hi = '{1'b1, 15'd0, 16'hFFFF, 16'hFFFF, 5'd15, 5'd15, 12'd0, 12'd600};

        // Empty map after reset: every ray walks off the map.
        rows.push_back('{'{16'h0000, 16'h0000, 12'd0, 12'd0}, 1, none300, 0});
        rows.push_back('{'{16'hFFFF, 16'hFFFF, 12'd4095, 12'd4095}, 1, none300, 0});
        rows.push_back('{'{16'h8000, 16'h8000, 12'd2048, 12'd1024}, 1, none300, 0});
        // Border map: starting inside a wall gives distance zero and a full slice.
        rows.push_back('{'{16'h0800, 16'h0800, 12'd0, 12'd0}, 1, wall_lo, 1});
        rows.push_back('{'{16'hFFFF, 16'hFFFF, 12'd3072, 12'd2048}, 1, wall_hi, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd0, 12'd0}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd1024, 12'd0}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd2048, 12'd100}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd3072, 12'd4000}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd4095, 12'd0}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h4800, 12'd512, 12'd0}, 0, '0, 0});
        rows.push_back('{'{16'h1000, 16'hE000, 12'd1536, 12'd0}, 0, '0, 0});
        // Column angle with zero cosine, and one behind the viewer: saturated slice.
        rows.push_back('{'{16'h4800, 16'h8800, 12'd0, 12'd1024}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd0, 12'd2048}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd0, 12'd3072}, 0, '0, 0});
        rows.push_back('{'{16'h4800, 16'h8800, 12'd0, 12'd1023}, 0, '0, 0});
        // One step short of a wall (slice clamped to the screen), then starting inside the border.
        rows.push_back('{'{16'h7FFF, 16'h8800, 12'd0, 12'd0}, 0, '0, 0});
        rows.push_back('{'{16'hEFFF, 16'h0FFF, 12'd3584, 12'd0}, 0, '0, 0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        m2 = 64'h8001_8001_8001_8101;   // border plus a block at tile (8, 8)
        foreach (rows[i]) begin
            if (rows[i].border_first) begin
                wait_drained();
                load_map(64'h8001_8001_8001_FFFF, 64'h8001_8001_8001_8001, m2,
                         64'hFFFF_8001_8001_8001);
            end
            typed_pending = rows[i].typed;
            typed_slice = rows[i].want;
            send_ray(rows[i].ray);
            typed_pending = 0;
            if ($urandom_range(0, 1) != 0) pause_rays($urandom_range(1, 4));
        end
        typed_pending = 0;
        random_rays(25, 1);

        // No marching at all and the smallest screen.
        wait_drained();
        load_map({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
        write_reg(REG_MAXD, 64'd0);
        write_reg(REG_PPD, 64'd0);
        write_reg(REG_SCRH, 64'd1);
        write_reg(REG_SPARE, '1);
        random_rays(12, 0);

        // Largest limits on a dense random map.
        wait_drained();
        load_map({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
        write_reg(REG_MAXD, 64'd32767);
        write_reg(REG_PPD, 64'd4095);
        write_reg(REG_SCRH, 64'd4095);
        random_rays(30, 0);

        // Short march limits on sparse maps, random slice settings.
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            load_map({$urandom, $urandom} & {$urandom, $urandom},
                     {$urandom, $urandom} & {$urandom, $urandom},
                     {$urandom, $urandom} & {$urandom, $urandom},
                     {$urandom, $urandom} & {$urandom, $urandom});
            write_reg(REG_MAXD, 64'($urandom_range(100, 3000)));
            write_reg(REG_PPD, 64'($urandom_range(0, 4095)));
            write_reg(REG_SCRH, 64'($urandom_range(1, 4095)));
            random_rays(12, 0);
        end

        while (slice_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
